// ----- sv/led_strip_animation_engine_macros.svh -----
// assertion macros shared by the animation engine rtl
`ifndef LED_STRIP_ANIMATION_ENGINE_MACROS_SVH
`define LED_STRIP_ANIMATION_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LSAE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsae same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define LSAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsae next-cycle check failed");

`endif

// ----- sv/lsae_pkg.sv -----
// constants, types and tables for the led strip animation engine
package lsae_pkg;

    // strip geometry
    localparam int PIXEL_COUNT = 8;
    localparam int PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    typedef logic [PIX_W-1:0] t_pix;

    // animation modes
    typedef enum logic [2:0] {
        MODE_FIXED   = 3'd0,
        MODE_WHEEL   = 3'd1,
        MODE_CHASE   = 3'd2,
        MODE_PULSE   = 3'd3,
        MODE_CANDY   = 3'd4,
        MODE_OCEAN   = 3'd5,
        MODE_AMBER   = 3'd6,
        MODE_OFF     = 3'd7
    } t_mode;

    // register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_RED   = 2'd1;
    localparam logic [1:0] REG_GREEN = 2'd2;
    localparam logic [1:0] REG_BLUE  = 2'd3;

    // register reset values
    localparam t_mode      MODE_RESET  = MODE_WHEEL;
    localparam logic [7:0] RED_RESET   = 8'd255;
    localparam logic [7:0] GREEN_RESET = 8'd90;
    localparam logic [7:0] BLUE_RESET  = 8'd0;

    // step intervals in ms
    localparam logic [8:0] INTERVAL_RAINBOW = 9'd24;
    localparam logic [8:0] INTERVAL_CHASE   = 9'd120;
    localparam logic [8:0] INTERVAL_BREATHE = 9'd28;
    localparam logic [8:0] INTERVAL_AMBER   = 9'd38;
    localparam logic [8:0] INTERVAL_ALT     = 9'd260;

    // breathe and amber bounce limits
    localparam logic [8:0] BREATHE_STEP = 9'd5;
    localparam logic [8:0] BREATHE_MAX  = 9'd255;
    localparam logic [7:0] BREATHE_MIN  = 8'd0;
    localparam logic [8:0] AMBER_STEP   = 9'd2;
    localparam logic [8:0] AMBER_MAX    = 9'd230;
    localparam logic [8:0] AMBER_MIN    = 9'd120;
    localparam logic [7:0] AMBER_RESET  = 8'd185;
    localparam logic [7:0] AMBER_GREEN_MUL = 8'd70;

    // color constants
    localparam logic [7:0] CHASE_LEVEL = 8'd180;
    localparam logic [7:0] WHEEL_THIRD = 8'd85;
    localparam logic [7:0] WHEEL_TWO_THIRDS = 8'd170;
    localparam logic [23:0] CANDY_EVEN = {8'd255, 8'd30,  8'd140};
    localparam logic [23:0] CANDY_ODD  = {8'd255, 8'd130, 8'd0};
    localparam logic [23:0] OCEAN_EVEN = {8'd0,   8'd90,  8'd255};
    localparam logic [23:0] OCEAN_ODD  = {8'd0,   8'd255, 8'd180};

    // per-pixel hue spacing, built at elaboration
    typedef logic [7:0] t_hue_table [PIXEL_COUNT];

    function automatic t_hue_table f_hue_table();
        t_hue_table tbl;
        for (int j = 0; j < PIXEL_COUNT; j++) begin
            tbl[j] = 8'((j * 256) / PIXEL_COUNT);
        end
        return tbl;
    endfunction

    localparam t_hue_table HUE_TABLE = f_hue_table();

endpackage

// ----- sv/led_strip_animation_engine.sv -----
// led strip animation engine: time words in, one frame of pixel words out per due step
//
// usage
//   input channel (i_valid / o_ready / i_time_ms) carries one word of millisecond time.
//   when the selected mode's interval has elapsed, or no step has happened since the
//   last mode write, the word causes one frame: PIXEL_COUNT pixel words on the output
//   channel (o_valid / i_ready), pixel 0 first, o_frame_last on the final pixel.
//   config port (i_cfg_we / i_cfg_index / i_cfg_data) writes the mode or one manual color
//   channel, chosen by index; write it only while no frame is pending. a mode write restarts timing.
//   a time word passes the input register and the frame sequencer, and its first pixel
//   word then loads into the output register. throughput: one pixel word per cycle while
//   the receiver does not stall; time words that cause no frame pass at one per cycle
//   while no frame is active. the next time word is taken in the cycle the last pixel
//   of the current frame loads into the output register, so frames run back to back.
//   reset: mode rainbow, manual color (255,90,0), no step taken yet.
//   receiver stall: the output register holds its word, the frame sequencer waits,
//   and the input register fills and then drops o_ready.
`include "led_strip_animation_engine_macros.svh"

module led_strip_animation_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_time_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_pixel_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_frame_last
);

    // configuration registers
    lsae_pkg::t_mode r_mode;
    logic [7:0]      r_man_r, r_man_g, r_man_b;

    // input register
    logic            r_in_valid;
    logic [31:0]     r_in_time;

    // animation state
    logic [31:0]     r_last_time;
    logic            r_step_valid;
    logic [7:0]      r_rainbow_off;
    logic [1:0]      r_chase_off;
    logic [7:0]      r_breathe_lvl;
    logic            r_breathe_up;
    logic [7:0]      r_amber_lvl;
    logic            r_amber_up;
    logic            r_alt_phase;

    // frame sequencer
    logic            r_frm_active;
    lsae_pkg::t_mode r_f_mode;
    logic [7:0]      r_f_lvl;
    logic [1:0]      r_f_chase_off;
    logic            r_f_phase;
    lsae_pkg::t_pix  r_pix;
    logic [1:0]      r_chase_c;

    // output register
    logic            r_out_valid;
    logic [5:0]      r_out_pix;
    logic [7:0]      r_out_r, r_out_g, r_out_b;
    logic            r_out_last;

    // control
    logic            pix_last, out_load, frm_free, consume, timed, due, start;
    logic [31:0]     elapsed;
    logic [8:0]      interval;

    // next-state values
    logic [7:0]      n_breathe_lvl, n_amber_lvl, snap_lvl;
    logic            n_breathe_up, n_amber_up;
    logic [8:0]      breathe_sum, amber_sum;
    logic [1:0]      chase_init, n_chase_off, n_chase_c;

    // pixel color path
    logic [7:0]      hue, wheel_p, wheel_q, wheel_q3;
    logic [7:0]      pix_r, pix_g, pix_b;
    logic [7:0]      wr, wg, wb;
    logic [15:0]     amber_prod;
    logic [16:0]     amber_div;
    logic            chase_lit, use_even;

    // handshake and frame decision
    assign pix_last = (r_pix == lsae_pkg::t_pix'(lsae_pkg::PIXEL_COUNT - 1));
    assign out_load = r_frm_active && (!r_out_valid || i_ready);
    assign frm_free = !r_frm_active || (out_load && pix_last);
    assign consume  = r_in_valid && frm_free;
    assign o_ready  = !r_in_valid || consume;
    assign elapsed  = r_in_time - r_last_time;

    always_comb begin
        timed    = 1'b1;
        interval = lsae_pkg::INTERVAL_ALT;
        unique case (r_mode)
            lsae_pkg::MODE_WHEEL:   interval = lsae_pkg::INTERVAL_RAINBOW;
            lsae_pkg::MODE_CHASE:   interval = lsae_pkg::INTERVAL_CHASE;
            lsae_pkg::MODE_PULSE:   interval = lsae_pkg::INTERVAL_BREATHE;
            lsae_pkg::MODE_AMBER:   interval = lsae_pkg::INTERVAL_AMBER;
            lsae_pkg::MODE_CANDY,
            lsae_pkg::MODE_OCEAN:   interval = lsae_pkg::INTERVAL_ALT;
            default:                timed    = 1'b0;
        endcase
    end

    assign due   = !r_step_valid || (timed && (elapsed >= {23'd0, interval}));
    assign start = consume && due;

    // breathe bounce 0..255 by 5
    assign breathe_sum = {1'b0, r_breathe_lvl} + lsae_pkg::BREATHE_STEP;
    always_comb begin
        n_breathe_lvl = r_breathe_lvl;
        n_breathe_up  = r_breathe_up;
        if (r_breathe_up) begin
            if (breathe_sum >= lsae_pkg::BREATHE_MAX) begin
                n_breathe_lvl = lsae_pkg::BREATHE_MAX[7:0];
                n_breathe_up  = 1'b0;
            end else begin
                n_breathe_lvl = breathe_sum[7:0];
            end
        end else if ({1'b0, r_breathe_lvl} <= lsae_pkg::BREATHE_STEP) begin
            n_breathe_lvl = lsae_pkg::BREATHE_MIN;
            n_breathe_up  = 1'b1;
        end else begin
            n_breathe_lvl = r_breathe_lvl - lsae_pkg::BREATHE_STEP[7:0];
        end
    end

    // amber bounce 120..230 by 2
    assign amber_sum = {1'b0, r_amber_lvl} + lsae_pkg::AMBER_STEP;
    always_comb begin
        n_amber_lvl = r_amber_lvl;
        n_amber_up  = r_amber_up;
        if (r_amber_up) begin
            if (amber_sum >= lsae_pkg::AMBER_MAX) begin
                n_amber_lvl = lsae_pkg::AMBER_MAX[7:0];
                n_amber_up  = 1'b0;
            end else begin
                n_amber_lvl = amber_sum[7:0];
            end
        end else if ({1'b0, r_amber_lvl} <= (lsae_pkg::AMBER_MIN + lsae_pkg::AMBER_STEP)) begin
            n_amber_lvl = lsae_pkg::AMBER_MIN[7:0];
            n_amber_up  = 1'b1;
        end else begin
            n_amber_lvl = r_amber_lvl - lsae_pkg::AMBER_STEP[7:0];
        end
    end

    // chase offset counts 0,1,2; phase counter starts at (-offset) mod 3
    assign n_chase_off = (r_chase_off == 2'd2) ? 2'd0 : r_chase_off + 2'd1;
    assign chase_init  = (r_chase_off == 2'd0) ? 2'd0 : 2'd3 - r_chase_off;
    assign n_chase_c   = (r_chase_c == 2'd2) ? 2'd0 : r_chase_c + 2'd1;

    // level captured for the frame
    always_comb begin
        snap_lvl = r_rainbow_off;
        unique case (r_mode)
            lsae_pkg::MODE_PULSE:   snap_lvl = r_breathe_lvl;
            lsae_pkg::MODE_AMBER:   snap_lvl = r_amber_lvl;
            default:                snap_lvl = r_rainbow_off;
        endcase
    end

    // color wheel
    assign hue     = lsae_pkg::HUE_TABLE[r_pix] + r_f_lvl;
    assign wheel_p = 8'd255 - hue;
    always_comb begin
        if (wheel_p < lsae_pkg::WHEEL_THIRD) begin
            wheel_q = wheel_p;
        end else if (wheel_p < lsae_pkg::WHEEL_TWO_THIRDS) begin
            wheel_q = wheel_p - lsae_pkg::WHEEL_THIRD;
        end else begin
            wheel_q = wheel_p - lsae_pkg::WHEEL_TWO_THIRDS;
        end
        wheel_q3 = {wheel_q[6:0], 1'b0} + wheel_q;
        if (wheel_p < lsae_pkg::WHEEL_THIRD) begin
            wr = 8'd255 - wheel_q3; wg = 8'd0;             wb = wheel_q3;
        end else if (wheel_p < lsae_pkg::WHEEL_TWO_THIRDS) begin
            wr = 8'd0;              wg = wheel_q3;         wb = 8'd255 - wheel_q3;
        end else begin
            wr = wheel_q3;          wg = 8'd255 - wheel_q3; wb = 8'd0;
        end
    end

    // amber green = level * 70 / 255, divide by 255 via add-and-shift
    assign amber_prod = 16'(r_f_lvl) * 16'(lsae_pkg::AMBER_GREEN_MUL);
    assign amber_div  = 17'(amber_prod) + 17'd1 + 17'(amber_prod[15:8]);

    assign chase_lit = (r_chase_c == 2'd0) && (7'(r_pix) >= 7'(r_f_chase_off));
    assign use_even  = (r_pix[0] == 1'b0) != r_f_phase;

    // pixel color select
    always_comb begin
        pix_r = 8'd0;
        pix_g = 8'd0;
        pix_b = 8'd0;
        unique case (r_f_mode)
            lsae_pkg::MODE_FIXED: begin
                pix_r = r_man_r; pix_g = r_man_g; pix_b = r_man_b;
            end
            lsae_pkg::MODE_WHEEL: begin
                pix_r = wr; pix_g = wg; pix_b = wb;
            end
            lsae_pkg::MODE_CHASE: begin
                pix_g = chase_lit ? lsae_pkg::CHASE_LEVEL : 8'd0;
                pix_b = chase_lit ? lsae_pkg::CHASE_LEVEL : 8'd0;
            end
            lsae_pkg::MODE_PULSE: begin
                pix_r = r_f_lvl; pix_g = r_f_lvl; pix_b = r_f_lvl;
            end
            lsae_pkg::MODE_CANDY: begin
                {pix_r, pix_g, pix_b} = use_even ? lsae_pkg::CANDY_EVEN : lsae_pkg::CANDY_ODD;
            end
            lsae_pkg::MODE_OCEAN: begin
                {pix_r, pix_g, pix_b} = use_even ? lsae_pkg::OCEAN_EVEN : lsae_pkg::OCEAN_ODD;
            end
            lsae_pkg::MODE_AMBER: begin
                pix_r = r_f_lvl; pix_g = amber_div[15:8];
            end
            default: begin
                pix_r = 8'd0;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= lsae_pkg::MODE_RESET;
            r_in_valid    <= 1'b0;
            r_step_valid  <= 1'b0;
            r_last_time   <= 32'd0;
            r_rainbow_off <= 8'd0;
            r_chase_off   <= 2'd0;
            r_breathe_lvl <= lsae_pkg::BREATHE_MIN;
            r_breathe_up  <= 1'b1;
            r_amber_lvl   <= lsae_pkg::AMBER_RESET;
            r_amber_up    <= 1'b1;
            r_alt_phase   <= 1'b0;
            r_frm_active  <= 1'b0;
            r_pix         <= '0;
            r_chase_c     <= 2'd0;
            r_out_valid   <= 1'b0;
        end else begin
            // input register
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end

            // frame start and animation step, else frame progress
            if (start) begin
                r_frm_active <= 1'b1;
                r_pix        <= '0;
                r_chase_c    <= chase_init;
                r_last_time  <= r_in_time;
                unique case (r_mode)
                    lsae_pkg::MODE_WHEEL:   r_rainbow_off <= r_rainbow_off + 8'd1;
                    lsae_pkg::MODE_CHASE:   r_chase_off   <= n_chase_off;
                    lsae_pkg::MODE_PULSE: begin
                        r_breathe_lvl <= n_breathe_lvl;
                        r_breathe_up  <= n_breathe_up;
                    end
                    lsae_pkg::MODE_CANDY,
                    lsae_pkg::MODE_OCEAN:   r_alt_phase <= !r_alt_phase;
                    lsae_pkg::MODE_AMBER: begin
                        r_amber_lvl <= n_amber_lvl;
                        r_amber_up  <= n_amber_up;
                    end
                    default: begin
                        r_alt_phase <= r_alt_phase;
                    end
                endcase
            end else if (out_load) begin
                r_pix     <= r_pix + lsae_pkg::t_pix'(1);
                r_chase_c <= n_chase_c;
                if (pix_last) begin
                    r_frm_active <= 1'b0;
                end
            end

            // mode write restarts timing, a frame start marks a step taken
            if (i_cfg_we && (i_cfg_index == lsae_pkg::REG_MODE)) begin
                r_mode       <= lsae_pkg::t_mode'(i_cfg_data[2:0]);
                r_step_valid <= 1'b0;
            end else if (start) begin
                r_step_valid <= 1'b1;
            end

            // output register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // manual color registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_man_r <= lsae_pkg::RED_RESET;
            r_man_g <= lsae_pkg::GREEN_RESET;
            r_man_b <= lsae_pkg::BLUE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lsae_pkg::REG_RED:   r_man_r <= i_cfg_data;
                lsae_pkg::REG_GREEN: r_man_g <= i_cfg_data;
                lsae_pkg::REG_BLUE:  r_man_b <= i_cfg_data;
                default:             r_man_r <= r_man_r;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_time <= i_time_ms;
        end
        if (start) begin
            r_f_mode      <= r_mode;
            r_f_lvl       <= snap_lvl;
            r_f_chase_off <= r_chase_off;
            r_f_phase     <= r_alt_phase;
        end
        if (out_load) begin
            r_out_pix  <= 6'(r_pix);
            r_out_r    <= pix_r;
            r_out_g    <= pix_g;
            r_out_b    <= pix_b;
            r_out_last <= pix_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_index = r_out_pix;
    assign o_red         = r_out_r;
    assign o_green       = r_out_g;
    assign o_blue        = r_out_b;
    assign o_frame_last  = r_out_last;

    // checks
    `LSAE_ASSERT_NOW(a_last_on_final_pixel, i_clk, i_rst_n, o_valid && o_frame_last,
        o_pixel_index == 6'(lsae_pkg::PIXEL_COUNT - 1))
    `LSAE_ASSERT_NOW(a_input_waits_on_frame, i_clk, i_rst_n, r_in_valid && !o_ready,
        r_frm_active)
    `LSAE_ASSERT_NEXT(a_mode_write_restarts, i_clk, i_rst_n,
        i_cfg_we && (i_cfg_index == lsae_pkg::REG_MODE), !r_step_valid)

endmodule

// ----- tb/sv/led_strip_animation_engine_tb.sv -----
// self-checking testbench for the led strip animation engine
`timescale 1ns / 1ps

module led_strip_animation_engine_tb;

    localparam int NUM_PIXELS   = lsae_pkg::PIXEL_COUNT;
    localparam int SETTLE       = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        logic [5:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_time_ms;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_pixel_index;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_frame_last;

    // predicted strip state, mirrors the block after reset
    lsae_pkg::t_mode lamp_mode = lsae_pkg::MODE_WHEEL;
    logic [7:0]  manual_r     = 8'd255;
    logic [7:0]  manual_g     = 8'd90;
    logic [7:0]  manual_b     = 8'd0;
    logic [31:0] last_step_ms = '0;
    bit          step_taken   = 1'b0;
    logic [7:0]  hue_offset   = '0;
    int          chase_pos    = 0;
    int          breathe_lvl  = 0;
    bit          breathe_up   = 1'b1;
    int          amber_lvl    = 185;
    bit          amber_up     = 1'b1;
    bit          alt_phase    = 1'b0;

    t_pixel pending_pixels[$];
    t_pixel due_pixel;
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    bit     idle_on        = 1'b1;
    int     rx_gap         = 0;
    int     rx_hold        = 0;

    led_strip_animation_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_time_ms     (i_time_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_index (o_pixel_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_frame_last  (o_frame_last)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int step_interval(input lsae_pkg::t_mode m);
        case (m)
            lsae_pkg::MODE_WHEEL: return 24;
            lsae_pkg::MODE_CHASE: return 120;
            lsae_pkg::MODE_PULSE: return 28;
            lsae_pkg::MODE_AMBER: return 38;
            lsae_pkg::MODE_CANDY,
            lsae_pkg::MODE_OCEAN: return 260;
            default:              return 1;
        endcase
    endfunction

    function automatic t_rgb wheel_color(input logic [7:0] hue);
        t_rgb c;
        int   pos;
        pos = 255 - hue;
        if (pos < 85) begin
            c.red = 8'(255 - pos * 3); c.green = 8'd0; c.blue = 8'(pos * 3);
        end else if (pos < 170) begin
            pos -= 85;
            c.red = 8'd0; c.green = 8'(pos * 3); c.blue = 8'(255 - pos * 3);
        end else begin
            pos -= 170;
            c.red = 8'(pos * 3); c.green = 8'(255 - pos * 3); c.blue = 8'd0;
        end
        return c;
    endfunction

    function automatic void queue_pixel(input int i, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
        t_pixel p;
        p.index = 6'(i);
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.last  = (i == NUM_PIXELS - 1);
        pending_pixels.push_back(p);
    endfunction

    // works out the frame, if any, that one time word causes
    function automatic void render_frame(input logic [31:0] now);
        logic [31:0] elapsed;
        logic [7:0]  hue;
        t_rgb        c;
        t_rgb        even_c;
        t_rgb        odd_c;
        bit          lit;
        int          i;

        // solid modes fire once per mode write
        if (lamp_mode == lsae_pkg::MODE_FIXED || lamp_mode == lsae_pkg::MODE_OFF) begin
            if (step_taken) return;
            step_taken   = 1'b1;
            last_step_ms = now;
            for (i = 0; i < NUM_PIXELS; i++) begin
                if (lamp_mode == lsae_pkg::MODE_FIXED)
                    queue_pixel(i, manual_r, manual_g, manual_b);
                else
                    queue_pixel(i, 8'd0, 8'd0, 8'd0);
            end
            return;
        end

        // interval check on wrapping time
        elapsed = now - last_step_ms;
        if (step_taken && elapsed < 32'(step_interval(lamp_mode))) return;
        last_step_ms = now;
        step_taken   = 1'b1;

        case (lamp_mode)
            lsae_pkg::MODE_WHEEL: begin
                for (i = 0; i < NUM_PIXELS; i++) begin
                    hue = 8'((i * 256) / NUM_PIXELS + hue_offset);
                    c   = wheel_color(hue);
                    queue_pixel(i, c.red, c.green, c.blue);
                end
                hue_offset = hue_offset + 8'd1;
            end
            lsae_pkg::MODE_CHASE: begin
                for (i = 0; i < NUM_PIXELS; i++) begin
                    lit = (i >= chase_pos) && (((i - chase_pos) % 3) == 0);
                    queue_pixel(i, 8'd0, lit ? 8'd180 : 8'd0, lit ? 8'd180 : 8'd0);
                end
                chase_pos = (chase_pos + 1) % 3;
            end
            lsae_pkg::MODE_PULSE: begin
                for (i = 0; i < NUM_PIXELS; i++)
                    queue_pixel(i, 8'(breathe_lvl), 8'(breathe_lvl), 8'(breathe_lvl));
                breathe_lvl += breathe_up ? 5 : -5;
                if (breathe_lvl >= 255) begin
                    breathe_lvl = 255;
                    breathe_up  = 1'b0;
                end else if (breathe_lvl <= 0) begin
                    breathe_lvl = 0;
                    breathe_up  = 1'b1;
                end
            end
            lsae_pkg::MODE_CANDY, lsae_pkg::MODE_OCEAN: begin
                if (lamp_mode == lsae_pkg::MODE_CANDY) begin
                    even_c = '{8'd255, 8'd30, 8'd140};
                    odd_c  = '{8'd255, 8'd130, 8'd0};
                end else begin
                    even_c = '{8'd0, 8'd90, 8'd255};
                    odd_c  = '{8'd0, 8'd255, 8'd180};
                end
                for (i = 0; i < NUM_PIXELS; i++) begin
                    if ((((i & 1) == 0) ? 1'b1 : 1'b0) != alt_phase)
                        queue_pixel(i, even_c.red, even_c.green, even_c.blue);
                    else
                        queue_pixel(i, odd_c.red, odd_c.green, odd_c.blue);
                end
                alt_phase = !alt_phase;
            end
            default: begin
                for (i = 0; i < NUM_PIXELS; i++)
                    queue_pixel(i, 8'(amber_lvl), 8'((amber_lvl * 70) / 255), 8'd0);
                amber_lvl += amber_up ? 2 : -2;
                if (amber_lvl >= 230) begin
                    amber_lvl = 230;
                    amber_up  = 1'b0;
                end else if (amber_lvl <= 120) begin
                    amber_lvl = 120;
                    amber_up  = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker, one pixel word per accepted handshake
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel word, expected none, actual index %0d",
                         $time, o_pixel_index);
                mismatch_count++;
            end else begin
                due_pixel = pending_pixels.pop_front();
                check_field("pixel_index", due_pixel.index, o_pixel_index);
                check_field("red", due_pixel.red, o_red);
                check_field("green", due_pixel.green, o_green);
                check_field("blue", due_pixel.blue, o_blue);
                check_field("frame_last", due_pixel.last, o_frame_last);
            end
            rx_gap = idle_on ? $urandom_range(0, 9) : 0;
        end
    end

    // receiver: random gaps per word, plus a long hold when requested
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                i_ready <= 1'b0;
                rx_gap--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // sends one time word and predicts its frame on acceptance
    task automatic send_time(input logic [31:0] t);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_time_ms <= t;
        do @(posedge i_clk); while (!o_ready);
        render_frame(t);
    endtask

    // config write, only called while the block is idle
    task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            lsae_pkg::REG_MODE: begin
                lamp_mode  = lsae_pkg::t_mode'(data[2:0]);
                step_taken = 1'b0;
            end
            lsae_pkg::REG_RED:   manual_r = data;
            lsae_pkg::REG_GREEN: manual_g = data;
            default:             manual_b = data;
        endcase
    endtask

    // waits until every predicted pixel has arrived, then lets the pipe settle
    task automatic wait_frames_done();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // reset state: rainbow, first word always fires, interval edges and time wrap
    task automatic test_reset_rainbow();
        send_time(32'h0000_0000);
        send_time(32'h0000_0017);
        send_time(32'h0000_0018);
        send_time(32'hFFFF_FFF0);
        send_time(32'h0000_0007);
        send_time(32'h0000_0008);
        wait_frames_done();
    endtask

    // solid frames once per mode write, color writes alone stay silent
    task automatic test_manual_and_off();
        write_reg(lsae_pkg::REG_RED, 8'd0);
        write_reg(lsae_pkg::REG_GREEN, 8'd255);
        write_reg(lsae_pkg::REG_BLUE, 8'd255);
        write_reg(lsae_pkg::REG_MODE, {5'b00000, lsae_pkg::MODE_FIXED});
        send_time(32'h1234_5678);
        send_time(32'h8000_0000);
        wait_frames_done();
        write_reg(lsae_pkg::REG_RED, 8'd255);
        send_time(32'h8000_1000);
        wait_frames_done();
        // upper mode bits are dropped
        write_reg(lsae_pkg::REG_MODE, {5'b11111, lsae_pkg::MODE_FIXED});
        send_time(32'h0000_0001);
        wait_frames_done();
        write_reg(lsae_pkg::REG_MODE, {5'b11111, lsae_pkg::MODE_OFF});
        send_time(32'hFFFF_FFFF);
        send_time(32'h0000_0000);
        wait_frames_done();
    endtask

    task automatic step_mode(input lsae_pkg::t_mode m, input int steps,
                             input logic [31:0] start);
        logic [31:0] t;
        t = start;
        write_reg(lsae_pkg::REG_MODE, {5'b00000, m});
        repeat (steps) begin
            send_time(t);
            t += 32'(step_interval(m));
        end
        // one word just short of the interval
        send_time(t - 32'(step_interval(m)) + 32'(step_interval(m) - 1));
        wait_frames_done();
    endtask

    // chase, pulse, candy, ocean and amber modes across a few steps
    task automatic test_animated_modes();
        step_mode(lsae_pkg::MODE_CHASE, 4, 32'h0000_1000);
        step_mode(lsae_pkg::MODE_PULSE, 2, 32'h5555_AAAA);
        step_mode(lsae_pkg::MODE_CANDY, 2, 32'hAAAA_5555);
        step_mode(lsae_pkg::MODE_OCEAN, 2, 32'h0F0F_F0F0);
        step_mode(lsae_pkg::MODE_AMBER, 2, 32'hF0F0_0F0F);
    endtask

    // receiver holds off while the sender keeps offering due words
    task automatic test_output_stall();
        logic [31:0] t;
        t = $urandom();
        idle_on = 1'b0;
        write_reg(lsae_pkg::REG_MODE, {5'b00000, lsae_pkg::MODE_WHEEL});
        rx_hold = STALL_CYCLES;
        repeat (20) begin
            send_time(t);
            t += 32'd24;
        end
        wait_frames_done();
        idle_on = 1'b1;
    endtask

    // random phases over every mode, mostly well-timed words with some noise
    task automatic test_random_phases();
        lsae_pkg::t_mode order[8];
        lsae_pkg::t_mode swap;
        logic [31:0]     t;
        int              k;
        int              pick;
        int              len;
        int              period;
        order = '{lsae_pkg::MODE_FIXED, lsae_pkg::MODE_WHEEL, lsae_pkg::MODE_CHASE,
                  lsae_pkg::MODE_PULSE, lsae_pkg::MODE_CANDY, lsae_pkg::MODE_OCEAN,
                  lsae_pkg::MODE_AMBER, lsae_pkg::MODE_OFF};
        for (k = 7; k > 0; k--) begin
            pick        = $urandom_range(0, k);
            swap        = order[k];
            order[k]    = order[pick];
            order[pick] = swap;
        end
        t = $urandom();
        foreach (order[m]) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (order[m] == lsae_pkg::MODE_FIXED || order[m] == lsae_pkg::MODE_OFF) begin
                repeat (2) begin
                    write_reg(lsae_pkg::REG_RED, 8'($urandom_range(0, 255)));
                    write_reg(lsae_pkg::REG_GREEN, 8'($urandom_range(0, 255)));
                    write_reg(lsae_pkg::REG_BLUE, 8'($urandom_range(0, 255)));
                    write_reg(lsae_pkg::REG_MODE, {5'($urandom_range(0, 31)), order[m]});
                    repeat (3) send_time($urandom());
                    wait_frames_done();
                end
            end else begin
                write_reg(lsae_pkg::REG_MODE, {5'($urandom_range(0, 31)), order[m]});
                period = step_interval(order[m]);
                len = (order[m] == lsae_pkg::MODE_PULSE) ? 75 :
                      (order[m] == lsae_pkg::MODE_AMBER) ? 60 : 6;
                repeat (len) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 16) t += 32'(period + $urandom_range(0, 9));
                    else if (pick < 19) t += 32'($urandom_range(0, period - 1));
                    else t = $urandom();
                    send_time(t);
                end
                wait_frames_done();
            end
        end
        idle_on = 1'b1;
    endtask

    // main sequence
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = lsae_pkg::REG_MODE;
        i_cfg_data  = 8'd0;
        i_valid     = 1'b0;
        i_time_ms   = 32'd0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_rainbow();
        test_manual_and_off();
        test_animated_modes();
        test_output_stall();
        test_random_phases();

        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
